// ===== src/sttd_pkg.sv =====
// ----------------------------------------------------------------------------
// sttd_pkg
// Shared types and constants of the timed task dispatcher: field widths,
// request and status codes, sequencer states and the slot and result records.
// ----------------------------------------------------------------------------
package sttd_pkg;

  // default sizes
  localparam int unsigned TASK_SLOTS_DEF  = 8;
  localparam int unsigned QUEUE_DEPTH_DEF = 16;

  // fixed field widths
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned ID_W     = 8;
  localparam int unsigned DELAY_W  = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned QLEN_W   = 5;
  localparam int unsigned SLOTO_W  = 3;
  localparam int unsigned FAIL_W   = 8;

  // request codes
  typedef enum logic [MODE_W-1:0] {
    MODE_SET    = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_TICK   = 2'd2,
    MODE_FETCH  = 2'd3
  } mode_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK           = 2'd0,
    STATUS_TABLE_FULL   = 2'd1,
    STATUS_QUEUE_EMPTY  = 2'd2,
    STATUS_TICK_STALLED = 2'd3
  } status_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SLOT_SCAN,
    ST_FIFO_SCAN,
    ST_FETCH,
    ST_POP,
    ST_DONE
  } state_e;

  // one timer table entry
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [DELAY_W-1:0] delay;
    logic [DELAY_W-1:0] period;
  } slot_t;

  // one result item
  typedef struct packed {
    status_e             status;
    logic [ID_W-1:0]     ready_task;
    logic [QLEN_W-1:0]   queue_length;
    logic [QLEN_W-1:0]   peak_queue_length;
    logic [SLOTO_W-1:0]  highest_slot;
    logic [FAIL_W-1:0]   set_failures;
  } result_t;

endpackage

// ===== src/sttd_ram.sv =====
// ----------------------------------------------------------------------------
// sttd_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module sttd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/sttd_seq.sv =====
// ----------------------------------------------------------------------------
// sttd_seq
// Request sequencer: walks the timer table RAM and the ready queue RAM with
// read-modify-write passes, and keeps the queue pointers and statistics.
// ----------------------------------------------------------------------------
module sttd_seq #(
  parameter int unsigned TASK_SLOTS  = sttd_pkg::TASK_SLOTS_DEF,
  parameter int unsigned QUEUE_DEPTH = sttd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [sttd_pkg::MODE_W-1:0]  mode_i,
  input  logic [sttd_pkg::ID_W-1:0]    task_id_i,
  input  logic [sttd_pkg::DELAY_W-1:0] start_delay_i,
  input  logic [sttd_pkg::DELAY_W-1:0] repeat_period_i,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output sttd_pkg::result_t            res_o
);

  localparam int unsigned SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int unsigned KW = $clog2(TASK_SLOTS + 1);
  localparam int unsigned QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned PW = ((QW > CW) ? QW : CW) + 1;
  localparam int unsigned SLOT_W = $bits(sttd_pkg::slot_t);
  localparam int unsigned ID_W = sttd_pkg::ID_W;

  // queue index plus offset, wrapped once around the ring
  function automatic logic [QW-1:0] qwrap(input logic [QW-1:0] base,
                                          input logic [CW-1:0] off);
    logic [PW-1:0] sum;
    sum = PW'(base) + PW'(off);
    if (sum >= PW'(QUEUE_DEPTH)) begin
      sum = sum - PW'(QUEUE_DEPTH);
    end
    return sum[QW-1:0];
  endfunction

  sttd_pkg::state_e state_q, state_d;
  sttd_pkg::mode_e  mode_q, mode_d;
  logic [ID_W-1:0]                  id_q, id_d;
  logic [sttd_pkg::DELAY_W-1:0]     dly_q, dly_d, per_q, per_d;
  logic [TASK_SLOTS-1:0]            valid_q, valid_d;
  logic [QW-1:0]                    head_q, head_d;
  logic [CW-1:0]                    count_q, count_d, fpeak_q, fpeak_d;
  logic [SW-1:0]                    speak_q, speak_d;
  logic [sttd_pkg::FAIL_W-1:0]      fail_q, fail_d;
  logic [KW-1:0]                    k_q, k_d;
  logic [CW-1:0]                    j_q, j_d;
  logic [QW-1:0]                    faddr_q, faddr_d;
  logic                             found_q, found_d;
  logic [SW-1:0]                    pick_q, pick_d;
  sttd_pkg::status_e                res_status_q, res_status_d;
  logic [ID_W-1:0]                  res_task_q, res_task_d;

  // RAM ports
  logic              slot_we;
  logic [SW-1:0]     slot_waddr, slot_raddr;
  sttd_pkg::slot_t   slot_wdata, slot_rdata;
  logic              fifo_we;
  logic [QW-1:0]     fifo_waddr, fifo_raddr;
  logic [ID_W-1:0]   fifo_wdata, fifo_rdata;

  // scan predicates
  logic [KW-1:0]     k_m1;
  logic [SW-1:0]     e_idx;
  sttd_pkg::slot_t   cur;
  logic              ev, last, hit, empty_now, busy, due, q_full, stall, fdone;

  // timer table and ready queue storage
  sttd_ram #(.WIDTH(SLOT_W), .DEPTH(TASK_SLOTS)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  sttd_ram #(.WIDTH(ID_W), .DEPTH(QUEUE_DEPTH)) u_fifo_ram (
    .clk_i   (clk_i),
    .we_i    (fifo_we),
    .waddr_i (fifo_waddr),
    .wdata_i (fifo_wdata),
    .raddr_i (fifo_raddr),
    .rdata_o (fifo_rdata)
  );

  // slot under evaluation is the one read in the previous cycle
  always_comb begin
    k_m1      = k_q - KW'(1);
    e_idx     = k_m1[SW-1:0];
    cur       = valid_q[e_idx] ? slot_rdata : '0;
    ev        = (state_q == sttd_pkg::ST_SLOT_SCAN) && (k_q != '0);
    last      = (k_q == KW'(TASK_SLOTS));
    hit       = (cur.id == id_q);
    empty_now = (cur.id == '0) && !found_q;
    busy      = (cur.id != '0);
    due       = busy && (cur.delay == '0);
    q_full    = (count_q == CW'(QUEUE_DEPTH));
    stall     = due && q_full;
    fdone     = (j_q == count_q);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sttd_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (sttd_pkg::mode_e'(mode_i) == sttd_pkg::MODE_FETCH) begin
            state_d = (count_q == '0) ? sttd_pkg::ST_DONE : sttd_pkg::ST_FETCH;
          end else begin
            state_d = sttd_pkg::ST_SLOT_SCAN;
          end
        end
      end
      sttd_pkg::ST_SLOT_SCAN: begin
        if (ev) begin
          case (mode_q)
            sttd_pkg::MODE_SET: begin
              if (hit || last) state_d = sttd_pkg::ST_DONE;
            end
            sttd_pkg::MODE_DELETE: begin
              if (hit || last) state_d = sttd_pkg::ST_FIFO_SCAN;
            end
            sttd_pkg::MODE_TICK: begin
              if (stall || last) state_d = sttd_pkg::ST_DONE;
            end
            default: state_d = sttd_pkg::ST_DONE;
          endcase
        end
      end
      sttd_pkg::ST_FIFO_SCAN: begin
        if (fdone) state_d = sttd_pkg::ST_DONE;
      end
      sttd_pkg::ST_FETCH: state_d = sttd_pkg::ST_POP;
      sttd_pkg::ST_POP:   state_d = sttd_pkg::ST_DONE;
      sttd_pkg::ST_DONE: begin
        if (res_ready_i) state_d = sttd_pkg::ST_IDLE;
      end
      default: state_d = sttd_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    mode_d       = mode_q;
    id_d         = id_q;
    dly_d        = dly_q;
    per_d        = per_q;
    valid_d      = valid_q;
    head_d       = head_q;
    count_d      = count_q;
    fpeak_d      = fpeak_q;
    speak_d      = speak_q;
    fail_d       = fail_q;
    k_d          = k_q;
    j_d          = j_q;
    faddr_d      = faddr_q;
    found_d      = found_q;
    pick_d       = pick_q;
    res_status_d = res_status_q;
    res_task_d   = res_task_q;

    slot_we    = 1'b0;
    slot_waddr = e_idx;
    slot_wdata = '{id: id_q, delay: dly_q, period: per_q};
    slot_raddr = k_q[SW-1:0];
    fifo_we    = 1'b0;
    fifo_waddr = faddr_q;
    fifo_wdata = '0;
    fifo_raddr = (state_q == sttd_pkg::ST_FETCH) ? head_q : qwrap(head_q, j_q);

    case (state_q)
      // capture the request
      sttd_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          mode_d       = sttd_pkg::mode_e'(mode_i);
          id_d         = task_id_i;
          dly_d        = start_delay_i;
          per_d        = repeat_period_i;
          k_d          = '0;
          j_d          = '0;
          found_d      = 1'b0;
          res_task_d   = '0;
          res_status_d = sttd_pkg::STATUS_OK;
          if ((sttd_pkg::mode_e'(mode_i) == sttd_pkg::MODE_FETCH) && (count_q == '0)) begin
            res_status_d = sttd_pkg::STATUS_QUEUE_EMPTY;
          end
        end
      end

      // table walk, one slot read and one slot evaluated per cycle
      sttd_pkg::ST_SLOT_SCAN: begin
        if (!last) k_d = k_q + KW'(1);
        if (ev) begin
          case (mode_q)
            sttd_pkg::MODE_SET: begin
              if (hit || (last && (found_q || empty_now))) begin
                slot_we    = 1'b1;
                slot_waddr = (hit || empty_now) ? e_idx : pick_q;
                valid_d[slot_waddr] = 1'b1;
                if (slot_waddr > speak_q) speak_d = slot_waddr;
              end else if (last) begin
                fail_d       = fail_q + 1'b1;
                res_status_d = sttd_pkg::STATUS_TABLE_FULL;
              end else if (empty_now) begin
                found_d = 1'b1;
                pick_d  = e_idx;
              end
            end
            sttd_pkg::MODE_DELETE: begin
              if (hit) valid_d[e_idx] = 1'b0;
            end
            sttd_pkg::MODE_TICK: begin
              if (due) begin
                if (q_full) begin
                  res_status_d = sttd_pkg::STATUS_TICK_STALLED;
                end else begin
                  fifo_we    = 1'b1;
                  fifo_waddr = qwrap(head_q, count_q);
                  fifo_wdata = cur.id;
                  count_d    = count_q + CW'(1);
                  if (count_d > fpeak_q) fpeak_d = count_d;
                  if (cur.period != '0) begin
                    slot_we    = 1'b1;
                    slot_wdata = '{id: cur.id, delay: cur.period, period: cur.period};
                  end else begin
                    valid_d[e_idx] = 1'b0;
                  end
                end
              end else if (busy) begin
                slot_we    = 1'b1;
                slot_wdata = '{id: cur.id, delay: cur.delay - 1'b1, period: cur.period};
              end
            end
            default: ;
          endcase
        end
      end

      // cancel queued copies of the deleted id
      sttd_pkg::ST_FIFO_SCAN: begin
        if (!fdone) begin
          j_d     = j_q + CW'(1);
          faddr_d = fifo_raddr;
        end
        if ((j_q != '0) && (fifo_rdata == id_q)) begin
          fifo_we    = 1'b1;
          fifo_waddr = faddr_q;
          fifo_wdata = '0;
        end
      end

      // pop the queue head
      sttd_pkg::ST_POP: begin
        res_task_d = fifo_rdata;
        head_d     = qwrap(head_q, CW'(1));
        count_d    = count_q - CW'(1);
      end

      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sttd_pkg::ST_IDLE;
      valid_q <= '0;
      head_q  <= '0;
      count_q <= '0;
      fpeak_q <= '0;
      speak_q <= '0;
      fail_q  <= '0;
      k_q     <= '0;
      j_q     <= '0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      head_q  <= head_d;
      count_q <= count_d;
      fpeak_q <= fpeak_d;
      speak_q <= speak_d;
      fail_q  <= fail_d;
      k_q     <= k_d;
      j_q     <= j_d;
      found_q <= found_d;
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    id_q         <= id_d;
    dly_q        <= dly_d;
    per_q        <= per_d;
    faddr_q      <= faddr_d;
    pick_q       <= pick_d;
    res_status_q <= res_status_d;
    res_task_q   <= res_task_d;
  end

  // result record, statistics cut to their field widths
  logic [CW+sttd_pkg::QLEN_W-1:0]  qlen_ext, qpeak_ext;
  logic [SW+sttd_pkg::SLOTO_W-1:0] speak_ext;

  always_comb begin
    qlen_ext                = {{sttd_pkg::QLEN_W{1'b0}}, count_q};
    qpeak_ext               = {{sttd_pkg::QLEN_W{1'b0}}, fpeak_q};
    speak_ext               = {{sttd_pkg::SLOTO_W{1'b0}}, speak_q};
    res_o.status            = res_status_q;
    res_o.ready_task        = res_task_q;
    res_o.queue_length      = qlen_ext[sttd_pkg::QLEN_W-1:0];
    res_o.peak_queue_length = qpeak_ext[sttd_pkg::QLEN_W-1:0];
    res_o.highest_slot      = speak_ext[sttd_pkg::SLOTO_W-1:0];
    res_o.set_failures      = fail_q;
  end

  assign res_valid_o = (state_q == sttd_pkg::ST_DONE);
  assign in_stall_o  = (state_q != sttd_pkg::ST_IDLE);

endmodule

// ===== src/software_timer_task_dispatcher.sv =====
// ----------------------------------------------------------------------------
// software_timer_task_dispatcher
// Timed task table with a ready queue, behind an output register.
// ----------------------------------------------------------------------------
// One item is processed at a time. A set or tick walks the timer table RAM,
// one slot per cycle; a set stops early when it finds its id, a tick when it
// stalls on a full queue. A delete walks the table until it finds the id and
// then the queued entries, one per cycle. A fetch reads the queue head and
// pops it; on an empty queue it goes straight to its result. The walks take
// one entry at a time because each RAM has a single read port. After reset
// every slot is empty at once; no clearing pass is needed. The result sits in
// an output register so that a finished item does not hold up the next
// request while that register is empty or being drained.
module software_timer_task_dispatcher #(
  parameter int unsigned TASK_SLOTS  = sttd_pkg::TASK_SLOTS_DEF,
  parameter int unsigned QUEUE_DEPTH = sttd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [sttd_pkg::MODE_W-1:0]   mode_i,
  input  logic [sttd_pkg::ID_W-1:0]     task_id_i,
  input  logic [sttd_pkg::DELAY_W-1:0]  start_delay_i,
  input  logic [sttd_pkg::DELAY_W-1:0]  repeat_period_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [sttd_pkg::STATUS_W-1:0] status_o,
  output logic [sttd_pkg::ID_W-1:0]     ready_task_o,
  output logic [sttd_pkg::QLEN_W-1:0]   queue_length_o,
  output logic [sttd_pkg::QLEN_W-1:0]   peak_queue_length_o,
  output logic [sttd_pkg::SLOTO_W-1:0]  highest_slot_o,
  output logic [sttd_pkg::FAIL_W-1:0]   set_failures_o
);

  logic              res_valid, res_ready;
  sttd_pkg::result_t res;
  sttd_pkg::result_t out_q;
  logic              out_valid_q, out_valid_d;

  sttd_seq #(
    .TASK_SLOTS  (TASK_SLOTS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .mode_i          (mode_i),
    .task_id_i       (task_id_i),
    .start_delay_i   (start_delay_i),
    .repeat_period_i (repeat_period_i),
    .res_valid_o     (res_valid),
    .res_ready_i     (res_ready),
    .res_o           (res)
  );

  // output register takes a new item when empty or being drained
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_ready) out_valid_d = res_valid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  // result fields
  assign out_valid_o         = out_valid_q;
  assign status_o            = out_q.status;
  assign ready_task_o        = out_q.ready_task;
  assign queue_length_o      = out_q.queue_length;
  assign peak_queue_length_o = out_q.peak_queue_length;
  assign highest_slot_o      = out_q.highest_slot;
  assign set_failures_o      = out_q.set_failures;

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the timed task dispatcher. A short table of
// directed items is sent first, then weighted random traffic in bursts of
// differing mix. Each result is compared with a hand-typed record or with
// an in-bench predictor of the slot table and the ready queue.
// ----------------------------------------------------------------------------
module tb;
  import sttd_pkg::*;

  localparam int unsigned SLOTS      = TASK_SLOTS_DEF;
  localparam int unsigned QDEPTH     = QUEUE_DEPTH_DEF;
  localparam int unsigned RAND_ITEMS = 1000;
  localparam int unsigned HOLD_CYC   = 300;
  localparam int unsigned CYCLE_CAP  = 500000;

  // directed stimulus row
  typedef struct {
    mode_e        mode;
    logic [7:0]   id;
    logic [15:0]  dly;
    logic [15:0]  per;
    bit           known;
    result_t      want;
  } dir_row_t;

  logic        clk;
  logic        rst_ni;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  mode_d;
  logic [7:0]  task_id_d;
  logic [15:0] start_delay_d;
  logic [15:0] repeat_period_d;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  status_q;
  logic [7:0]  ready_task_q;
  logic [4:0]  queue_length_q;
  logic [4:0]  peak_queue_length_q;
  logic [2:0]  highest_slot_q;
  logic [7:0]  set_failures_q;

  // predictor state
  logic [7:0]  tbl_id     [SLOTS];
  logic [15:0] tbl_delay  [SLOTS];
  logic [15:0] tbl_period [SLOTS];
  logic [7:0]  ready_q    [QDEPTH];
  int unsigned ready_len;
  int unsigned ready_peak;
  int unsigned slot_hi;
  logic [7:0]  fail_cnt;

  result_t     pending_results[$];
  dir_row_t    dir_rows[$];
  int unsigned mismatch_cnt;
  int unsigned cycle_cnt;
  bit          quiet;
  bit          hold_req;
  int unsigned hold_left;

  software_timer_task_dispatcher dut (
    .clk_i               (clk),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .mode_i              (mode_d),
    .task_id_i           (task_id_d),
    .start_delay_i       (start_delay_d),
    .repeat_period_i     (repeat_period_d),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .status_o            (status_q),
    .ready_task_o        (ready_task_q),
    .queue_length_o      (queue_length_q),
    .peak_queue_length_o (peak_queue_length_q),
    .highest_slot_o      (highest_slot_q),
    .set_failures_o      (set_failures_q)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor of one request against the table and queue
  function automatic result_t predict_dispatch(mode_e m, logic [7:0] id,
                                               logic [15:0] dly, logic [15:0] per);
    result_t     r;
    bit          found;
    int unsigned pick;
    r = '0;
    r.status = STATUS_OK;
    case (m)
      MODE_SET: begin
        found = 1'b0;
        pick  = 0;
        for (int unsigned s = 0; s < SLOTS; s++) begin
          if (tbl_id[s] == id) begin
            pick  = s;
            found = 1'b1;
            break;
          end
          if (tbl_id[s] == 8'd0 && !found) begin
            pick  = s;
            found = 1'b1;
          end
        end
        if (!found) begin
          fail_cnt = fail_cnt + 8'd1;
          r.status = STATUS_TABLE_FULL;
        end else begin
          tbl_id[pick]     = id;
          tbl_delay[pick]  = dly;
          tbl_period[pick] = per;
          if (pick > slot_hi) slot_hi = pick;
        end
      end
      MODE_DELETE: begin
        for (int unsigned s = 0; s < SLOTS; s++) begin
          if (tbl_id[s] == id) begin
            tbl_id[s]     = 8'd0;
            tbl_delay[s]  = 16'd0;
            tbl_period[s] = 16'd0;
            break;
          end
        end
        // cancel queued copies in place
        for (int unsigned q = 0; q < ready_len; q++) begin
          if (ready_q[q] == id) ready_q[q] = 8'd0;
        end
      end
      MODE_TICK: begin
        for (int unsigned s = 0; s < SLOTS; s++) begin
          if (tbl_id[s] == 8'd0) continue;
          if (tbl_delay[s] == 16'd0) begin
            // walk stops at the first due slot that cannot be queued
            if (ready_len >= QDEPTH) begin
              r.status = STATUS_TICK_STALLED;
              break;
            end
            ready_q[ready_len] = tbl_id[s];
            ready_len++;
            if (ready_len > ready_peak) ready_peak = ready_len;
            if (tbl_period[s] != 16'd0) begin
              tbl_delay[s] = tbl_period[s];
            end else begin
              tbl_id[s]     = 8'd0;
              tbl_delay[s]  = 16'd0;
              tbl_period[s] = 16'd0;
            end
          end else begin
            tbl_delay[s] = tbl_delay[s] - 16'd1;
          end
        end
      end
      default: begin
        if (ready_len == 0) begin
          r.status = STATUS_QUEUE_EMPTY;
        end else begin
          r.ready_task = ready_q[0];
          for (int unsigned q = 0; q + 1 < ready_len; q++) ready_q[q] = ready_q[q + 1];
          ready_len--;
          ready_q[ready_len] = 8'd0;
        end
      end
    endcase
    r.queue_length      = ready_len[4:0];
    r.peak_queue_length = ready_peak[4:0];
    r.highest_slot      = slot_hi[2:0];
    r.set_failures      = fail_cnt;
    return r;
  endfunction

  // result record typed in by hand
  function automatic result_t known_result(status_e st, logic [7:0] rt, logic [4:0] ql,
                                           logic [4:0] pk, logic [2:0] hs, logic [7:0] sf);
    result_t r;
    r.status            = st;
    r.ready_task        = rt;
    r.queue_length      = ql;
    r.peak_queue_length = pk;
    r.highest_slot      = hs;
    r.set_failures      = sf;
    return r;
  endfunction

  function automatic void add_row(mode_e m, logic [7:0] id, logic [15:0] dly,
                                  logic [15:0] per, bit known, result_t want);
    dir_row_t row;
    row.mode  = m;
    row.id    = id;
    row.dly   = dly;
    row.per   = per;
    row.known = known;
    row.want  = want;
    dir_rows.push_back(row);
  endfunction

  // request mix for one burst: mixed, loading, running, draining
  function automatic mode_e pick_mode(int unsigned mix);
    int unsigned w;
    w = $urandom_range(99);
    case (mix)
      1:       return (w < 55) ? MODE_SET : (w < 65) ? MODE_DELETE :
                      (w < 85) ? MODE_TICK : MODE_FETCH;
      2:       return (w < 10) ? MODE_SET : (w < 15) ? MODE_DELETE :
                      (w < 80) ? MODE_TICK : MODE_FETCH;
      3:       return (w < 10) ? MODE_SET : (w < 20) ? MODE_DELETE :
                      (w < 35) ? MODE_TICK : MODE_FETCH;
      default: return (w < 25) ? MODE_SET : (w < 35) ? MODE_DELETE :
                      (w < 70) ? MODE_TICK : MODE_FETCH;
    endcase
  endfunction

  // ids mostly from a small pool so that sets and deletes meet each other
  function automatic logic [7:0] pick_id();
    int unsigned w;
    w = $urandom_range(99);
    if (w < 80) return 8'($urandom_range(12, 1));
    if (w < 88) return 8'd0;
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [15:0] pick_delay();
    int unsigned w;
    w = $urandom_range(99);
    if (w < 70) return 16'($urandom_range(3));
    if (w < 90) return 16'($urandom_range(20));
    return 16'($urandom_range(65535));
  endfunction

  function automatic logic [15:0] pick_period();
    int unsigned w;
    w = $urandom_range(99);
    if (w < 30) return 16'd0;
    if (w < 80) return 16'($urandom_range(4, 1));
    return 16'($urandom_range(65535));
  endfunction

  // offer one item, wait for acceptance, record what it should produce
  task automatic offer_item(mode_e m, logic [7:0] id, logic [15:0] dly,
                            logic [15:0] per, bit known, result_t want);
    result_t pred;
    if (!quiet) begin
      while ($urandom_range(99) < 8) begin
        in_valid = 1'b0;
        @(negedge clk);
      end
    end
    in_valid        = 1'b1;
    mode_d          = m;
    task_id_d       = id;
    start_delay_d   = dly;
    repeat_period_d = per;
    do @(posedge clk); while (in_stall);
    pred = predict_dispatch(m, id, dly, per);
    pending_results.push_back(known ? want : pred);
    @(negedge clk);
  endtask

  // receiver stall, with one long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall = 1'b1;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYC;
      out_stall = 1'b1;
    end else begin
      out_stall = !quiet && ($urandom_range(99) < 8);
    end
  end

  // result checking
  always @(posedge clk) begin
    result_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result: status %0d ready %0d qlen %0d", status_q,
                   ready_task_q, queue_length_q);
      end else begin
        want = pending_results.pop_front();
        if (status_q !== want.status || ready_task_q !== want.ready_task ||
            queue_length_q !== want.queue_length ||
            peak_queue_length_q !== want.peak_queue_length ||
            highest_slot_q !== want.highest_slot || set_failures_q !== want.set_failures) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $write("mismatch: exp st %0d rt %0d ql %0d pk %0d hs %0d sf %0d,",
                   want.status, want.ready_task, want.queue_length,
                   want.peak_queue_length, want.highest_slot, want.set_failures);
            $display(" got st %0d rt %0d ql %0d pk %0d hs %0d sf %0d",
                     status_q, ready_task_q, queue_length_q, peak_queue_length_q,
                     highest_slot_q, set_failures_q);
          end
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // stimulus
  initial begin
    int unsigned mix;
    mode_e       m;
    result_t     none;
    rst_ni          = 1'b0;
    in_valid        = 1'b0;
    mode_d          = MODE_SET;
    task_id_d       = 8'd0;
    start_delay_d   = 16'd0;
    repeat_period_d = 16'd0;
    out_stall       = 1'b0;
    quiet           = 1'b0;
    hold_req        = 1'b0;
    hold_left       = 0;
    mismatch_cnt    = 0;
    cycle_cnt       = 0;
    mix             = 0;
    none            = '0;
    for (int unsigned s = 0; s < SLOTS; s++) begin
      tbl_id[s]     = 8'd0;
      tbl_delay[s]  = 16'd0;
      tbl_period[s] = 16'd0;
    end
    for (int unsigned q = 0; q < QDEPTH; q++) ready_q[q] = 8'd0;
    ready_len  = 0;
    ready_peak = 0;
    slot_hi    = 0;
    fail_cnt   = 8'd0;

    // directed table: empty queue, empty table, idle id, cancelled entry,
    // full table, full queue stalling a tick
    add_row(MODE_FETCH, 8'd0, 16'd0, 16'd0, 1'b1,
            known_result(STATUS_QUEUE_EMPTY, 8'd0, 5'd0, 5'd0, 3'd0, 8'd0));
    add_row(MODE_TICK, 8'd0, 16'd0, 16'd0, 1'b1,
            known_result(STATUS_OK, 8'd0, 5'd0, 5'd0, 3'd0, 8'd0));
    add_row(MODE_DELETE, 8'd5, 16'd0, 16'd0, 1'b1,
            known_result(STATUS_OK, 8'd0, 5'd0, 5'd0, 3'd0, 8'd0));
    add_row(MODE_SET, 8'd0, 16'hFFFF, 16'hFFFF, 1'b1,
            known_result(STATUS_OK, 8'd0, 5'd0, 5'd0, 3'd0, 8'd0));
    add_row(MODE_DELETE, 8'd0, 16'd0, 16'd0, 1'b0, none);
    add_row(MODE_SET, 8'hFF, 16'd0, 16'd0, 1'b0, none);
    add_row(MODE_SET, 8'd1, 16'd0, 16'd1, 1'b0, none);
    add_row(MODE_TICK, 8'd0, 16'd0, 16'd0, 1'b0, none);
    add_row(MODE_SET, 8'd1, 16'd0, 16'd0, 1'b0, none);
    add_row(MODE_DELETE, 8'hFF, 16'd0, 16'd0, 1'b0, none);
    add_row(MODE_FETCH, 8'd0, 16'd0, 16'd0, 1'b0, none);
    add_row(MODE_FETCH, 8'd0, 16'd0, 16'd0, 1'b0, none);
    for (int unsigned k = 10; k <= 16; k++)
      add_row(MODE_SET, 8'(k), 16'd0, 16'd1, 1'b0, none);
    add_row(MODE_SET, 8'd17, 16'd0, 16'd1, 1'b1,
            known_result(STATUS_TABLE_FULL, 8'd0, 5'd0, 5'd2, 3'd7, 8'd1));
    for (int unsigned k = 0; k < 5; k++)
      add_row(MODE_TICK, 8'd0, 16'd0, 16'd0, 1'b0, none);

    // reset
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;
    @(negedge clk);

    // directed part
    foreach (dir_rows[i])
      offer_item(dir_rows[i].mode, dir_rows[i].id, dir_rows[i].dly, dir_rows[i].per,
                 dir_rows[i].known, dir_rows[i].want);

    // random part in bursts of varying mix
    for (int unsigned n = 0; n < RAND_ITEMS; n++) begin
      if (n % 40 == 0) mix = $urandom_range(3);
      if (n == 200) hold_req = 1'b1;
      // sender pause until the block has delivered everything
      if (n == 450) begin
        in_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
      end
      quiet = (n >= 600 && n < 800);
      m = pick_mode(mix);
      offer_item(m, pick_id(), pick_delay(), pick_period(), 1'b0, none);
    end
    in_valid = 1'b0;
    quiet    = 1'b0;

    // drain and let the block settle
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/sttd_pkg.sv
src/sttd_ram.sv
src/sttd_seq.sv
src/software_timer_task_dispatcher.sv
verif/tb.sv
